FILE: hw/rtl/utm_pkg.sv
// ----------------------------------------------------------------------------
// utm_pkg
// Shared types and constants of the UTF-8 text width measurer.
// ----------------------------------------------------------------------------
package utm_pkg;

  // glyph table geometry
  localparam int GLYPH_DEPTH = 256;
  localparam int IDX_W       = (GLYPH_DEPTH > 1) ? $clog2(GLYPH_DEPTH) : 1;
  localparam int CNT_W       = $clog2(GLYPH_DEPTH + 1);
  localparam int GCOUNT_W    = 9;
  localparam int N_W         = (CNT_W > GCOUNT_W) ? CNT_W : GCOUNT_W;

  // stream payload widths
  localparam int S_DATA_W = 40;
  localparam int M_DATA_W = 24;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 9;

  // command queue between front and back
  localparam int QDEPTH = 4;
  localparam int Q_W    = $clog2(QDEPTH);

  // character codes
  localparam logic [15:0] QMARK     = 16'h003F;
  localparam logic [15:0] SPACE     = 16'h0020;
  localparam logic [15:0] WIDTH_MAX = 16'hFFFF;

  // utf-8 lead and continuation masks
  localparam logic [7:0] LEAD_ASCII_MASK = 8'h80;
  localparam logic [7:0] LEAD2_MASK      = 8'hE0;
  localparam logic [7:0] LEAD2_CODE      = 8'hC0;
  localparam logic [7:0] LEAD3_MASK      = 8'hF0;
  localparam logic [7:0] LEAD3_CODE      = 8'hE0;
  localparam logic [7:0] LEAD2_BITS      = 8'h1F;
  localparam logic [7:0] LEAD3_BITS      = 8'h0F;
  localparam logic [7:0] CONT_BITS       = 8'h3F;

  // reciprocal of three for an 8-bit value: (x * 171) >> 9
  localparam logic [16:0] THIRD_MUL   = 17'd171;
  localparam int          THIRD_SHIFT = 9;

  localparam logic [7:0] LINE_HEIGHT_RST = 8'd16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GLYPH_COUNT = 1'b0,
    CFG_LINE_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_TEXT = 1'b1
  } cmd_kind_e;

  typedef enum logic [1:0] {
    B_IDLE,
    B_START,
    B_PROBE,
    B_EMIT
  } back_state_e;

  // one queued command
  typedef struct packed {
    cmd_kind_e   kind;
    logic [7:0]  idx;     // load slot
    logic [15:0] code;    // code point or loaded glyph code
    logic [7:0]  adv;     // loaded glyph advance
    logic        has_cp;  // a complete code point is to be measured
    logic        trunc;   // string ended mid-sequence, add '?'
    logic        last;    // emit the total afterwards
  } cmd_t;

  // queue status
  typedef struct packed {
    logic         full;
    logic         empty;
    logic [Q_W:0] count;
  } fifo_stat_t;

endpackage

FILE: hw/rtl/utm_front.sv
// ----------------------------------------------------------------------------
// utm_front
// Accepts input items, decodes UTF-8 bytes and queues lookup or load commands.
// ----------------------------------------------------------------------------
module utm_front import utm_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_tvalid_i,
  output logic                s_tready_o,
  input  logic [S_DATA_W-1:0] s_tdata_i,
  input  logic                s_tuser_i,
  input  logic                s_tlast_i,
  output logic                push_o,
  output cmd_t                cmd_o,
  input  logic                full_i
);

  logic [1:0]  pend_q, pend_d;
  logic [15:0] part_q, part_d;
  logic        acc;
  logic [7:0]  in_idx, in_adv, in_byte;
  logic [15:0] in_code;
  logic [1:0]  pend_nx;

  assign s_tready_o = !full_i;
  assign acc        = s_tvalid_i && !full_i;

  assign in_idx  = s_tdata_i[7:0];
  assign in_code = s_tdata_i[23:8];
  assign in_adv  = s_tdata_i[31:24];
  assign in_byte = s_tdata_i[39:32];

  // decode one item into a command
  always_comb begin
    pend_d  = pend_q;
    part_d  = part_q;
    pend_nx = pend_q;
    push_o  = 1'b0;
    cmd_o   = '0;
    cmd_o.idx  = in_idx;
    cmd_o.adv  = in_adv;
    cmd_o.code = in_code;
    if (acc) begin
      if (cmd_kind_e'(s_tuser_i) == CMD_LOAD) begin
        cmd_o.kind = CMD_LOAD;
        push_o     = (int'(in_idx) < GLYPH_DEPTH);
      end else begin
        cmd_o.kind = CMD_TEXT;
        push_o     = 1'b1;
        if (pend_q == 2'd0) begin
          priority if ((in_byte & LEAD_ASCII_MASK) == 8'h00) begin
            cmd_o.has_cp = 1'b1;
            cmd_o.code   = {8'h00, in_byte};
          end else if ((in_byte & LEAD2_MASK) == LEAD2_CODE) begin
            part_d  = {5'd0, in_byte[4:0] & LEAD2_BITS[4:0], 6'd0};
            pend_nx = 2'd1;
          end else if ((in_byte & LEAD3_MASK) == LEAD3_CODE) begin
            part_d  = {in_byte[3:0] & LEAD3_BITS[3:0], 12'd0};
            pend_nx = 2'd2;
          end else begin
            cmd_o.has_cp = 1'b1;
            cmd_o.code   = QMARK;
          end
        end else if (pend_q == 2'd2) begin
          part_d  = part_q | {4'd0, in_byte[5:0] & CONT_BITS[5:0], 6'd0};
          pend_nx = 2'd1;
        end else begin
          cmd_o.has_cp = 1'b1;
          cmd_o.code   = part_q | {10'd0, in_byte[5:0] & CONT_BITS[5:0]};
          pend_nx      = 2'd0;
        end
        pend_d = pend_nx;
        // end of string resets the decoder
        if (s_tlast_i) begin
          cmd_o.last  = 1'b1;
          cmd_o.trunc = (pend_nx != 2'd0);
          pend_d      = 2'd0;
          part_d      = '0;
        end
      end
    end
  end

  // decoder state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 2'd0;
      part_q <= '0;
    end else begin
      pend_q <= pend_d;
      part_q <= part_d;
    end
  end

endmodule

FILE: hw/rtl/utm_cmd_fifo.sv
// ----------------------------------------------------------------------------
// utm_cmd_fifo
// Short command queue that lets the decoder and the search unit stall apart.
// ----------------------------------------------------------------------------
module utm_cmd_fifo import utm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  cmd_t       cmd_i,
  input  logic       pop_i,
  output cmd_t       cmd_o,
  output fifo_stat_t stat_o
);

  cmd_t           slot_q [QDEPTH];
  logic [Q_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [Q_W:0]   count_q;
  logic           do_push, do_pop;

  assign stat_o.full  = (count_q == (Q_W + 1)'(QDEPTH));
  assign stat_o.empty = (count_q == '0);
  assign stat_o.count = count_q;
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign cmd_o        = slot_q[rd_ptr_q];

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (do_push && !do_pop)      count_q <= count_q + 1'b1;
      else if (!do_push && do_pop) count_q <= count_q - 1'b1;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) slot_q[wr_ptr_q] <= cmd_i;
  end

endmodule

FILE: hw/rtl/utm_back.sv
// ----------------------------------------------------------------------------
// utm_back
// Glyph table, binary search, width accumulator and result register.
// ----------------------------------------------------------------------------
module utm_back import utm_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  cmd_t                  cmd_i,
  input  logic                  empty_i,
  output logic                  pop_o,
  output logic                  m_tvalid_o,
  input  logic                  m_tready_i,
  output logic [M_DATA_W-1:0]   m_tdata_o
);

  back_state_e state_q, state_d;
  logic [GCOUNT_W-1:0] gcount_q, gcount_d;
  logic [7:0]          lheight_q, lheight_d;
  logic [N_W-1:0]      lo_q, lo_d, hx_q, hx_d, mid_q, mid_d;
  logic [15:0]         key_q, key_d;
  logic                second_q, second_d, last_q, last_d;
  logic [15:0]         sum_q, sum_d;
  logic                sat_q, sat_d;
  logic                out_valid_q, out_valid_d;
  logic [16:0]         out_data_q;

  logic [23:0]      glyph_mem [GLYPH_DEPTH];
  logic [23:0]      rd_q;
  logic             rd_en, wr_en;
  logic [IDX_W-1:0] rd_addr, wr_addr;

  logic [N_W-1:0] n_lim, nlo, nhx;
  logic [N_W:0]   mid_start, mid_next;
  logic [16:0]    third_mul;
  logic [7:0]     third;
  logic [15:0]    p_code;
  logic [7:0]     p_adv;
  logic           fin, add_en, out_load;
  logic [7:0]     add_amt;
  logic [16:0]    add_sum;

  assign cfg_ready_o = 1'b1;
  assign p_code      = rd_q[23:8];
  assign p_adv       = rd_q[7:0];
  assign wr_addr     = IDX_W'(cmd_i.idx);

  // search bounds and a third of the line height
  always_comb begin
    n_lim     = (int'(gcount_q) > GLYPH_DEPTH) ? N_W'(GLYPH_DEPTH) : N_W'(gcount_q);
    mid_start = ({1'b0, n_lim} - 1'b1) >> 1;
    nlo       = (p_code < key_q) ? (mid_q + 1'b1) : lo_q;
    nhx       = (p_code < key_q) ? hx_q : mid_q;
    mid_next  = ({1'b0, nlo} + {1'b0, nhx} - 1'b1) >> 1;
    third_mul = {9'd0, lheight_q} * THIRD_MUL;
    third     = third_mul[THIRD_SHIFT +: 8];
  end

  // configuration writes
  always_comb begin
    gcount_d  = gcount_q;
    lheight_d = lheight_q;
    if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_GLYPH_COUNT: gcount_d  = cfg_data_i;
        CFG_LINE_HEIGHT: lheight_d = cfg_data_i[7:0];
      endcase
    end
  end

  // sequencer: next state and outputs
  always_comb begin
    state_d  = state_q;
    lo_d     = lo_q;
    hx_d     = hx_q;
    mid_d    = mid_q;
    key_d    = key_q;
    second_d = second_q;
    last_d   = last_q;
    pop_o    = 1'b0;
    wr_en    = 1'b0;
    rd_en    = 1'b0;
    rd_addr  = mid_start[IDX_W-1:0];
    fin      = 1'b0;
    add_en   = 1'b0;
    add_amt  = '0;
    out_load = 1'b0;
    unique case (state_q)
      B_IDLE: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          if (cmd_i.kind == CMD_LOAD) begin
            wr_en = 1'b1;
          end else begin
            key_d    = cmd_i.has_cp ? cmd_i.code : QMARK;
            second_d = cmd_i.has_cp && cmd_i.trunc;
            last_d   = cmd_i.last;
            if (cmd_i.has_cp || cmd_i.trunc) state_d = B_START;
            else if (cmd_i.last)             state_d = B_EMIT;
          end
        end
      end
      B_START: begin
        lo_d = '0;
        hx_d = n_lim;
        if (n_lim == '0) begin
          fin = 1'b1;
          if (key_q == SPACE) begin
            add_en  = 1'b1;
            add_amt = third;
          end
        end else begin
          rd_en   = 1'b1;
          rd_addr = mid_start[IDX_W-1:0];
          mid_d   = mid_start[N_W-1:0];
          state_d = B_PROBE;
        end
      end
      B_PROBE: begin
        if (p_code == key_q) begin
          fin     = 1'b1;
          add_en  = 1'b1;
          add_amt = p_adv;
        end else begin
          lo_d = nlo;
          hx_d = nhx;
          if (nlo < nhx) begin
            rd_en   = 1'b1;
            rd_addr = mid_next[IDX_W-1:0];
            mid_d   = mid_next[N_W-1:0];
          end else begin
            fin = 1'b1;
            if (key_q == SPACE) begin
              add_en  = 1'b1;
              add_amt = third;
            end
          end
        end
      end
      B_EMIT: begin
        if (!out_valid_q || m_tready_i) begin
          out_load = 1'b1;
          state_d  = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
    // lookup finished: truncated tail lookup, emit or back to idle
    if (fin) begin
      if (second_q) begin
        key_d    = QMARK;
        second_d = 1'b0;
        state_d  = B_START;
      end else begin
        state_d = last_q ? B_EMIT : B_IDLE;
      end
    end
  end

  // saturating width accumulator
  always_comb begin
    add_sum = {1'b0, sum_q} + {9'd0, add_amt};
    sum_d   = sum_q;
    sat_d   = sat_q;
    if (add_en) begin
      if (add_sum[16]) begin
        sum_d = WIDTH_MAX;
        sat_d = 1'b1;
      end else begin
        sum_d = add_sum[15:0];
      end
    end
    if (out_load) begin
      sum_d = '0;
      sat_d = 1'b0;
    end
  end

  // output handshake
  always_comb begin
    if (out_load)        out_valid_d = 1'b1;
    else if (m_tready_i) out_valid_d = 1'b0;
    else                 out_valid_d = out_valid_q;
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = {7'd0, out_data_q};

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      gcount_q    <= '0;
      lheight_q   <= LINE_HEIGHT_RST;
      second_q    <= 1'b0;
      last_q      <= 1'b0;
      sum_q       <= '0;
      sat_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      gcount_q    <= gcount_d;
      lheight_q   <= lheight_d;
      second_q    <= second_d;
      last_q      <= last_d;
      sum_q       <= sum_d;
      sat_q       <= sat_d;
      out_valid_q <= out_valid_d;
    end
  end

  // search and result payload
  always_ff @(posedge clk_i) begin
    lo_q  <= lo_d;
    hx_q  <= hx_d;
    mid_q <= mid_d;
    key_q <= key_q == key_d ? key_q : key_d;
    if (out_load) out_data_q <= {sat_q, sum_q};
  end

  // glyph table: code in the upper bits, advance in the lower
  always_ff @(posedge clk_i) begin
    if (wr_en) glyph_mem[wr_addr] <= {cmd_i.code, cmd_i.adv};
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) rd_q <= glyph_mem[rd_addr];
  end

endmodule

FILE: hw/rtl/utf8_text_width_measure.sv
// ----------------------------------------------------------------------------
// utf8_text_width_measure
// Measures the pixel width of a UTF-8 string against a sorted glyph table.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries items. tuser is op (0 loads a glyph slot, 1 is a text byte),
//   tlast marks the final byte of a string. Loads to slots at or above the
//   table depth are dropped. m_* carries one result per string: the width,
//   saturated at 65535, and the overflow flag. cfg_* writes glyph_count
//   (index 0) and line_height (index 1) and is always ready; write it only
//   while no string is in flight.
//   Throughput: the decoder takes one item a cycle into a four-entry command
//   queue while the queue is not full. The search unit writes a load at its
//   queue pop and takes no new command until a lookup ends: a code point
//   gets a start step, then binary search probes (at most 9 probes for 256
//   entries), as each probe reads the single table port and compares before
//   the next address. A truncated string costs one more search for '?'.
//   After the final lookup the emit state loads the output register once it
//   is empty or being read. If the receiver stalls, one result waits in the
//   output register while further items are still decoded and searched;
//   the search unit holds only when a second result is ready. Reset clears
//   the decoder, sum, queue and control registers, not the glyph table.
// ----------------------------------------------------------------------------
module utf8_text_width_measure import utm_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_tvalid_i,
  output logic                  s_tready_o,
  // [7:0] entry_index, [23:8] entry_code, [31:24] entry_advance,
  // [39:32] text_byte
  input  logic [S_DATA_W-1:0]   s_tdata_i,
  // [0] op
  input  logic                  s_tuser_i,
  // last
  input  logic                  s_tlast_i,
  output logic                  m_tvalid_o,
  input  logic                  m_tready_i,
  // [15:0] text_width, [16] overflow, [23:17] zero
  output logic [M_DATA_W-1:0]   m_tdata_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic       push, pop;
  cmd_t       push_cmd, head_cmd;
  fifo_stat_t q_stat;

  utm_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .s_tuser_i  (s_tuser_i),
    .s_tlast_i  (s_tlast_i),
    .push_o     (push),
    .cmd_o      (push_cmd),
    .full_i     (q_stat.full)
  );

  utm_cmd_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (push_cmd),
    .pop_i  (pop),
    .cmd_o  (head_cmd),
    .stat_o (q_stat)
  );

  utm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (head_cmd),
    .empty_i     (q_stat.empty),
    .pop_o       (pop),
    .m_tvalid_o  (m_tvalid_o),
    .m_tready_i  (m_tready_i),
    .m_tdata_o   (m_tdata_o)
  );

  // decoder never pushes into a full queue
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_stat.full)
    else $error("command pushed into full queue");

  // search unit never pops an empty queue
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_stat.empty)
    else $error("command popped from empty queue");

  // fill level rises on a push without a pop
  a_count_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (q_stat.count == $past(q_stat.count) + 1'b1))
    else $error("queue level did not rise on push");

endmodule
